>>> src/vntc_pkg.sv
// Shared types and constants for the vector norm tolerance compare block.
`default_nettype none

package vntc_pkg;

  localparam int ELEM_W     = 16;
  localparam int ACC_W      = 48;
  localparam int NORM_W     = 32;
  localparam int ROOT_W     = ACC_W / 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 2 * ELEM_W;
  localparam int OUT_DATA_W = 72;

  localparam logic [NORM_W-1:0] NORM_MAX = '1;
  localparam logic [ACC_W-1:0]  ACC_MAX  = '1;

  typedef enum logic [1:0] {
    MODE_L1  = 2'd0,
    MODE_L2  = 2'd1,
    MODE_INF = 2'd2,
    MODE_BAD = 2'd3
  } mode_t;

  localparam logic [CFG_ADDR_W-1:0] REG_NORM_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE = 1'b1;

  typedef struct packed {
    logic [ACC_W-1:0] acc_a;
    logic [ACC_W-1:0] acc_b;
    mode_t            mode;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROOT,
    BK_CMP,
    BK_HOLD
  } bk_state_t;

endpackage

`default_nettype wire

>>> src/vntc_front.sv
// Front end: accepts element pairs and accumulates both norms, one pair per cycle while the queue is not full.
`default_nettype none

module vntc_front
  import vntc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,  // elem_a, elem_b
  input  wire logic                 in_tlast,  // last_element
  input  wire mode_t                mode,
  input  wire logic                 q_full,
  output logic                      job_push,
  output job_t                      job
);

  logic [ACC_W-1:0]  acc_a_r, acc_a_nxt;
  logic [ACC_W-1:0]  acc_b_r, acc_b_nxt;
  logic [ACC_W-1:0]  step_a, step_b;
  logic [ELEM_W-1:0] mag_a, mag_b;
  logic              accept;

  function automatic logic [ELEM_W-1:0] magnitude(input logic [ELEM_W-1:0] v);
    return v[ELEM_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [ACC_W-1:0] acc_step(input logic [ACC_W-1:0] acc,
                                                input logic [ELEM_W-1:0] mag,
                                                input mode_t m);
    logic [ACC_W:0]      sum;
    logic [2*ELEM_W-1:0] sq;
    logic [ACC_W-1:0]    mag_x;
    sq    = mag * mag;
    mag_x = {{(ACC_W-ELEM_W){1'b0}}, mag};
    unique case (m)
      MODE_L1:  sum = {1'b0, acc} + {1'b0, mag_x};
      MODE_L2:  sum = {1'b0, acc} + {{(ACC_W+1-2*ELEM_W){1'b0}}, sq};
      MODE_INF: sum = {1'b0, (mag_x > acc) ? mag_x : acc};
      default:  sum = {1'b0, acc};
    endcase
    return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign mag_a     = magnitude(in_tdata[ELEM_W-1:0]);
  assign mag_b     = magnitude(in_tdata[2*ELEM_W-1:ELEM_W]);
  assign step_a    = acc_step(acc_a_r, mag_a, mode);
  assign step_b    = acc_step(acc_b_r, mag_b, mode);

  always_comb begin
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    if (accept) begin
      acc_a_nxt = in_tlast ? '0 : step_a;
      acc_b_nxt = in_tlast ? '0 : step_b;
    end
  end

  assign job_push  = accept && in_tlast;
  assign job.acc_a = step_a;
  assign job.acc_b = step_b;
  assign job.mode  = mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else begin
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/vntc_queue.sv
// Two-entry queue of finished accumulations between front and back end.
`default_nettype none

module vntc_queue
  import vntc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t job_in,
  input  wire logic pop,
  output job_t      job_out,
  output logic      full,
  output logic      empty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign job_out = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

>>> src/vntc_back.sv
// Back end: square root, saturation, tolerance compare and result register.
`default_nettype none

module vntc_back
  import vntc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire job_t                  job,
  input  wire logic                  q_empty,
  output logic                       job_pop,
  input  wire logic [NORM_W-1:0]     tolerance,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // norm_a, norm_b, within_tolerance, pad
  output logic                       out_tuser   // status
);

  bk_state_t          state_r, state_nxt;
  job_t               job_r;
  logic [ROOT_W+1:0]  rem_a_r, rem_b_r;
  logic [ROOT_W-1:0]  root_a_r, root_b_r;
  logic [STEP_W-1:0]  cnt_r;
  logic [NORM_W-1:0]  norm_a_r, norm_b_r;
  logic               within_r, status_r;
  logic [2*ROOT_W+1:0] step_a, step_b;
  logic [NORM_W-1:0]  na, nb, diff;

  function automatic logic [2*ROOT_W+1:0] root_step(input logic [ROOT_W+1:0] rem,
                                                    input logic [ROOT_W-1:0] root,
                                                    input logic [1:0] pair);
    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+1:0] rem_n;
    logic [ROOT_W-1:0] root_n;
    rem_sh = {rem, pair};
    trial  = {2'b00, root, 2'b01};
    if (rem_sh >= trial) begin
      rem_n  = ROOT_W'(0) + (ROOT_W+2)'(rem_sh - trial);
      root_n = {root[ROOT_W-2:0], 1'b1};
    end else begin
      rem_n  = rem_sh[ROOT_W+1:0];
      root_n = {root[ROOT_W-2:0], 1'b0};
    end
    return {rem_n, root_n};
  endfunction

  function automatic logic [NORM_W-1:0] sat_norm(input logic [ACC_W-1:0] acc);
    return (acc > {{(ACC_W-NORM_W){1'b0}}, NORM_MAX}) ? NORM_MAX : acc[NORM_W-1:0];
  endfunction

  assign step_a = root_step(rem_a_r, root_a_r, job_r.acc_a[ACC_W-1:ACC_W-2]);
  assign step_b = root_step(rem_b_r, root_b_r, job_r.acc_b[ACC_W-1:ACC_W-2]);

  always_comb begin
    if (job_r.mode == MODE_L2) begin
      na = {{(NORM_W-ROOT_W){1'b0}}, root_a_r};
      nb = {{(NORM_W-ROOT_W){1'b0}}, root_b_r};
    end else begin
      na = sat_norm(job_r.acc_a);
      nb = sat_norm(job_r.acc_b);
    end
    diff = (na > nb) ? (na - nb) : (nb - na);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = (job.mode == MODE_L2) ? BK_ROOT : BK_CMP;
        end
      end
      BK_ROOT: begin
        if (cnt_r == STEP_W'(ROOT_STEPS - 1)) begin
          state_nxt = BK_CMP;
        end
      end
      BK_CMP:  state_nxt = BK_HOLD;
      BK_HOLD: begin
        if (out_tready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop    = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      BK_IDLE: job_pop    = !q_empty;
      BK_HOLD: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign out_tdata = {{(OUT_DATA_W-2*NORM_W-1){1'b0}}, within_r, norm_b_r, norm_a_r};
  assign out_tuser = status_r;

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        job_r    <= job;
        rem_a_r  <= '0;
        rem_b_r  <= '0;
        root_a_r <= '0;
        root_b_r <= '0;
        cnt_r    <= '0;
      end
      BK_ROOT: begin
        rem_a_r     <= step_a[2*ROOT_W+1:ROOT_W];
        root_a_r    <= step_a[ROOT_W-1:0];
        rem_b_r     <= step_b[2*ROOT_W+1:ROOT_W];
        root_b_r    <= step_b[ROOT_W-1:0];
        job_r.acc_a <= {job_r.acc_a[ACC_W-3:0], 2'b00};
        job_r.acc_b <= {job_r.acc_b[ACC_W-3:0], 2'b00};
        cnt_r       <= cnt_r + 1'b1;
      end
      BK_CMP: begin
        if (job_r.mode == MODE_BAD) begin
          norm_a_r <= '0;
          norm_b_r <= '0;
          within_r <= 1'b0;
          status_r <= 1'b1;
        end else begin
          norm_a_r <= na;
          norm_b_r <= nb;
          within_r <= (diff <= tolerance);
          status_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[2*NORM_W:0] == '0))
    else $error("error result carries norm data");
  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (state_r != BK_IDLE))
    else $error("request taken but back end stayed idle");
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && job_r.mode == MODE_L2) |->
      (out_tdata[NORM_W-1:ROOT_W] == '0 && out_tdata[2*NORM_W-1:NORM_W+ROOT_W] == '0))
    else $error("square root result out of range");
`endif

endmodule

`default_nettype wire

>>> src/vector_norm_tolerance_compare_top.sv
// Top level: configuration registers and front, queue and back end.
//
// Input channel in_*: one element pair per request, elem_a in in_tdata[15:0],
// elem_b in in_tdata[31:16], in_tlast marks the final pair of a vector.
// Output channel out_*: one request per vector, norm_a in out_tdata[31:0],
// norm_b in out_tdata[63:32], within_tolerance in out_tdata[64],
// status in out_tuser (1 for an invalid norm mode).
// Configuration: cfg_we with cfg_addr 0 writes norm_mode, 1 writes tolerance.
// The front end takes one pair per cycle while the queue is not full and
// accumulates both norms. On the last pair the sums enter a two-entry queue;
// the back end finishes them, and for L2 it runs a 24-step shift-subtract
// square root.
// A stalled receiver holds the result; the front end keeps accepting pairs
// until the queue fills, and then holds in_tready low on the next vector.
// Reset clears the accumulators, the queue and the registers (mode L1,
// tolerance 0); no memory clearing pass is needed.
`default_nettype none

module vector_norm_tolerance_compare_top
  import vntc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // elem_a, elem_b
  input  wire logic                  in_tlast,   // last_element
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // norm_a, norm_b, within_tolerance, pad
  output logic                       out_tuser,  // status
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  mode_t             mode_r;
  logic [NORM_W-1:0] tolerance_r;
  job_t              job_in, job_out;
  logic              job_push, job_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_L1;
      tolerance_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NORM_MODE: mode_r      <= mode_t'(cfg_wdata[1:0]);
        REG_TOLERANCE: tolerance_r <= cfg_wdata[NORM_W-1:0];
        default: ;
      endcase
    end
  end

  vntc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .mode      (mode_r),
    .q_full    (q_full),
    .job_push  (job_push),
    .job       (job_in)
  );

  vntc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .job_in  (job_in),
    .pop     (job_pop),
    .job_out (job_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  vntc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (job_out),
    .q_empty    (q_empty),
    .job_pop    (job_pop),
    .tolerance  (tolerance_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
